// ----- rtl/core/register_calculator_execute_unit_defines.svh -----
// Assertion macros shared by the register calculator RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef REGISTER_CALCULATOR_EXECUTE_UNIT_DEFINES_SVH
`define REGISTER_CALCULATOR_EXECUTE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RCX_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RCX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RCX_ASSERT_SAME(lbl, ante, cons)
`define RCX_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/rcx_pkg.sv -----
// Shared types and constants for the register calculator execute unit.
// No dependencies.
package rcx_pkg;

	localparam int DATA_W       = 32;
	localparam int FIELD_IDX_W  = 5;
	localparam int IDX_RANGE    = 2 ** FIELD_IDX_W;
	localparam int FUNC_W       = 3;
	localparam int NUM_REGS_DEF = 32;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD = 3'd0,
		FN_SUB = 3'd1,
		FN_MUL = 3'd2,
		FN_DIV = 3'd3,
		FN_MOV = 3'd4,
		FN_CMP = 3'd5
	} func_t;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic                     first_is_reg;
		logic [FIELD_IDX_W-1:0]   first_index;
		logic signed [DATA_W-1:0] first_imm;
		logic                     second_is_reg;
		logic [FIELD_IDX_W-1:0]   second_index;
		logic signed [DATA_W-1:0] second_imm;
	} cmd_t;

	typedef struct packed {
		logic [FIELD_IDX_W-1:0]   dest_index;
		logic signed [DATA_W-1:0] dest_value;
		logic                     div_zero;
	} rsp_t;

endpackage

// ----- rtl/core/rcx_regfile.sv -----
// Register file: one write port, two registered read ports, per-entry valid bits.
// Depends on rcx_pkg.
module rcx_regfile import rcx_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEF,
	localparam int AW = $clog2(NUM_REGS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr_a,
	input  logic [AW-1:0]     rd_addr_b,
	output logic [DATA_W-1:0] rd_data_a,
	output logic [DATA_W-1:0] rd_data_b,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [DATA_W-1:0] data_a_q, data_b_q;
	logic vld_a_q, vld_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_a_q <= mem[rd_addr_a];
			data_b_q <= mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_q <= valid_q[rd_addr_a];
				vld_b_q <= valid_q[rd_addr_b];
			end
		end
	end

	assign rd_data_a = vld_a_q ? data_a_q : '0;
	assign rd_data_b = vld_b_q ? data_b_q : '0;

endmodule

// ----- rtl/core/rcx_divider.sv -----
// Signed 32-bit divider, restoring, one quotient bit per cycle, truncates toward zero.
// Depends on rcx_pkg and the assertion macro header. Divisor must be nonzero.
`include "register_calculator_execute_unit_defines.svh"
module rcx_divider import rcx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DATA_W + 1);

	logic [DATA_W-1:0] dvd_q, dvs_q, rem_q;
	logic neg_q;
	logic busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DATA_W:0] shifted, trial;

	assign shifted = {rem_q, dvd_q[DATA_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
			dvs_q <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
			rem_q <= '0;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
			dvd_q <= {dvd_q[DATA_W-2:0], ~trial[DATA_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? (~dvd_q + 1'b1) : dvd_q;

	`RCX_ASSERT_NEXT(a_div_last_step, busy_q && !start && cnt_q == CNT_W'(1), done_q && !busy_q)
	`RCX_ASSERT_SAME(a_div_no_restart, start, !busy_q)
	`RCX_ASSERT_NEXT(a_div_done_pulse, done_q && !start, !done_q && !busy_q)

endmodule

// ----- rtl/core/register_calculator_execute_unit.sv -----
// Top level of the register calculator execute unit: sequencer, ALU and result register.
// Depends on rcx_pkg, rcx_regfile, rcx_divider and the assertion macro header.
// One item is worked at a time. Add, subtract, multiply, compare and undefined
// operations pass through read, execute and done; move adds a clear step (its second
// write clears the source over the single write port), and divide waits in a divide
// state on the divider that retires one quotient bit per cycle; divide by zero skips it.
// The register file is read once per item, on accept, and written back at the end,
// so items never overlap on it. A finished result waits in the output register while
// the next item is accepted.
`include "register_calculator_execute_unit_defines.svh"
module register_calculator_execute_unit import rcx_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IDX_W = $clog2(NUM_REGS);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_EXEC = 6'b000100,
		S_DIV  = 6'b001000,
		S_CLR  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;
	cmd_t item_q;
	logic [IDX_W-1:0] i1_q, i2_q, dest_q;
	logic [DATA_W-1:0] a_q, b_q, res_q;
	logic dz_q, we_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [IDX_W-1:0] idx_tab [IDX_RANGE];
	logic [IDX_W-1:0] ra, rb;
	logic cmd_acc, rsp_free;
	logic [DATA_W-1:0] rd_a, rd_b;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic div_start, div_busy, div_done;
	logic [DATA_W-1:0] div_quot;
	logic is_mov, is_div;

	for (genvar v = 0; v < IDX_RANGE; v++) begin : g_idx_tab
		assign idx_tab[v] = IDX_W'(v % NUM_REGS);
	end

	assign ra = cmd.first_is_reg ? idx_tab[cmd.first_index] : '0;
	assign rb = cmd.second_is_reg ? idx_tab[cmd.second_index] : '0;

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc   = cmd_valid && (state_q == S_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign is_mov = (item_q.func == FN_MOV);
	assign is_div = (item_q.func == FN_DIV);

	assign div_start = (state_q == S_EXEC) && is_div && (b_q != '0);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = dest_q;
		wr_data = res_q;
		case (state_q)
			S_EXEC: begin
				wr_en   = is_mov;
				wr_addr = i1_q;
				wr_data = b_q;
			end
			S_CLR: begin
				wr_en   = 1'b1;
				wr_addr = i2_q;
				wr_data = '0;
			end
			S_DONE: begin
				wr_en = we_q && rsp_free;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	rcx_regfile #(
		.NUM_REGS(NUM_REGS)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (cmd_acc),
		.rd_addr_a (ra),
		.rd_addr_b (rb),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	rcx_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (a_q),
		.divisor  (b_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			item_q <= cmd;
			i1_q   <= ra;
			i2_q   <= rb;
		end
		if (state_q == S_READ) begin
			a_q <= item_q.first_is_reg ? rd_a : item_q.first_imm;
			// move always takes a register source, index 0 for an immediate
			b_q <= (item_q.second_is_reg || is_mov) ? rd_b : item_q.second_imm;
		end
		if (state_q == S_EXEC) begin
			dest_q <= (item_q.func inside {[FN_ADD:FN_MOV]}) ? i1_q : '0;
			dz_q   <= is_div && (b_q == '0);
			case (func_t'(item_q.func))
				FN_ADD: res_q <= a_q + b_q;
				FN_SUB: res_q <= a_q - b_q;
				FN_MUL: res_q <= DATA_W'(a_q * b_q);
				FN_DIV: res_q <= '1;
				FN_MOV: res_q <= (i1_q == i2_q) ? '0 : b_q;
				FN_CMP: begin
					if ($signed(a_q) > $signed(b_q)) begin
						res_q <= DATA_W'(1);
					end else if ($signed(a_q) < $signed(b_q)) begin
						res_q <= '1;
					end else begin
						res_q <= '0;
					end
				end
				default: begin
					res_q <= '0;
				end
			endcase
		end
		if (state_q == S_DIV && div_done) begin
			res_q <= div_quot;
		end
		if (state_q == S_DONE && rsp_free) begin
			rsp_q.dest_index <= FIELD_IDX_W'(dest_q);
			rsp_q.dest_value <= res_q;
			rsp_q.div_zero   <= dz_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			we_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					we_q <= (item_q.func == FN_ADD) || (item_q.func == FN_SUB) ||
						(item_q.func == FN_MUL) || is_div || (item_q.func == FN_CMP);
					if (div_start) begin
						state_q <= S_DIV;
					end else if (is_mov) begin
						state_q <= S_CLR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_CLR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`RCX_ASSERT_NEXT(a_accept_reads, cmd_acc, state_q == S_READ)
	`RCX_ASSERT_SAME(a_div_wait, state_q == S_DIV, div_busy || div_done)
	`RCX_ASSERT_SAME(a_no_wr_on_read, state_q == S_IDLE || state_q == S_READ, !wr_en)

endmodule

// ----- dv/tb_register_calculator_execute_unit.sv -----
// Self-checking testbench for register_calculator_execute_unit.
// Directed table then random instructions, checked against table or in-bench register model.
// Depends on rcx_pkg and the RTL of the execute unit.
`timescale 1ns / 100ps
module tb_register_calculator_execute_unit;
	import rcx_pkg::*;

	localparam int NREGS        = NUM_REGS_DEF;
	localparam int RANDOM_ITEMS = 500;
	localparam int CALM_ITEMS   = 100;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 60;

	localparam logic [FUNC_W-1:0] FN_UNDEF_A = 3'd6;
	localparam logic [FUNC_W-1:0] FN_UNDEF_B = 3'd7;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct {
		cmd_t c;
		bit   known;
		rsp_t r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	logic [DATA_W-1:0] model_regs [NREGS];
	rsp_t              pending_rsp [$];
	row_t              plan [$];
	bit                bursts_on = 1'b1;
	int unsigned       rsp_hold = 0;
	int unsigned       quiet_cycles = 0;
	int unsigned       mismatches = 0;

	register_calculator_execute_unit #(
		.NUM_REGS(NREGS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	function automatic int unsigned reg_sel(logic [FIELD_IDX_W-1:0] idx);
		return int'(idx) % NREGS;
	endfunction

	function automatic rsp_t execute_model(cmd_t c);
		int unsigned i1, i2, dst;
		logic [DATA_W-1:0] a, b, res;
		longint qa, qb;
		rsp_t r;
		i1 = c.first_is_reg ? reg_sel(c.first_index) : 0;
		i2 = c.second_is_reg ? reg_sel(c.second_index) : 0;
		a = c.first_is_reg ? model_regs[i1] : c.first_imm;
		b = c.second_is_reg ? model_regs[i2] : c.second_imm;
		dst = i1;
		res = '0;
		r = '0;
		case (c.func)
			FN_ADD: begin
				res = a + b;
				model_regs[dst] = res;
			end
			FN_SUB: begin
				res = a - b;
				model_regs[dst] = res;
			end
			FN_MUL: begin
				res = a * b;
				model_regs[dst] = res;
			end
			FN_DIV: begin
				if (b == '0) begin
					res = '1;
					r.div_zero = 1'b1;
				end else begin
					qa = longint'($signed(a));
					qb = longint'($signed(b));
					res = 32'(qa / qb);
				end
				model_regs[dst] = res;
			end
			FN_MOV: begin
				model_regs[i1] = model_regs[i2];
				model_regs[i2] = '0;
				res = model_regs[i1];
			end
			FN_CMP: begin
				dst = 0;
				if ($signed(a) > $signed(b))
					res = 32'd1;
				else if ($signed(a) < $signed(b))
					res = '1;
				else
					res = '0;
				model_regs[0] = res;
			end
			default: begin
				dst = 0;
				res = '0;
			end
		endcase
		r.dest_index = dst[FIELD_IDX_W-1:0];
		r.dest_value = res;
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '0;
			3: return '1;
			4, 5: return int'($urandom_range(0, 16)) - 8;
			default: return $urandom;
		endcase
	endfunction

	// unused fields of each instruction get random filler
	function automatic cmd_t rr(logic [FUNC_W-1:0] f, logic [4:0] fi, logic [4:0] si);
		return cmd_t'{f, 1'b1, fi, $urandom, 1'b1, si, $urandom};
	endfunction

	function automatic cmd_t ri(logic [FUNC_W-1:0] f, logic [4:0] fi,
			logic signed [DATA_W-1:0] sv);
		return cmd_t'{f, 1'b1, fi, $urandom, 1'b0, 5'($urandom), sv};
	endfunction

	function automatic cmd_t ir(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] fv,
			logic [4:0] si);
		return cmd_t'{f, 1'b0, 5'($urandom), fv, 1'b1, si, $urandom};
	endfunction

	function automatic cmd_t ii(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] fv,
			logic signed [DATA_W-1:0] sv);
		return cmd_t'{f, 1'b0, 5'($urandom), fv, 1'b0, 5'($urandom), sv};
	endfunction

	task automatic row(cmd_t c);
		plan.push_back('{c, 1'b0, rsp_t'('0)});
	endtask

	task automatic row_is(cmd_t c, logic [4:0] di, logic signed [DATA_W-1:0] dv, logic dz);
		plan.push_back('{c, 1'b1, rsp_t'{di, dv, dz}});
	endtask

	task automatic send(cmd_t c, bit known, rsp_t want);
		rsp_t predicted;
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		predicted = execute_model(c);
		pending_rsp.push_back(known ? want : predicted);
	endtask

	always @(posedge clk) begin
		if (rsp_hold != 0) begin
			rsp_stall <= 1'b1;
			rsp_hold <= rsp_hold - 1;
		end else if (bursts_on && $urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			rsp_hold <= $urandom_range(0, 4);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: idx %0d val %0d dz %0b",
						rsp.dest_index, rsp.dest_value, rsp.div_zero);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.dest_index !== want.dest_index || rsp.dest_value !== want.dest_value
						|| rsp.div_zero !== want.div_zero) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected idx %0d val %0d dz %0b, got idx %0d val %0d dz %0b",
							want.dest_index, want.dest_value, want.div_zero,
							rsp.dest_index, rsp.dest_value, rsp.div_zero);
				end
			end
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("FAIL register_calculator_execute_unit");
		$finish;
	end

	initial begin
		cmd_t c;
		int unsigned pick;
		cmd_valid = 1'b0;
		cmd = '0;
		rsp_stall = 1'b0;
		arst_n = 1'b0;
		for (int i = 0; i < NREGS; i++)
			model_regs[i] = '0;

		row_is(rr(FN_ADD, 5, 6), 5, 0, 0);
		row_is(ri(FN_ADD, 1, VAL_MAX), 1, VAL_MAX, 0);
		row_is(ri(FN_ADD, 1, 1), 1, VAL_MIN, 0);
		row_is(ri(FN_SUB, 2, VAL_MIN), 2, VAL_MIN, 0);
		row_is(ii(FN_MUL, VAL_MAX, VAL_MAX), 0, 1, 0);
		row_is(ri(FN_DIV, 1, -1), 1, VAL_MIN, 0);
		row_is(ii(FN_DIV, 7, 0), 0, -1, 1);
		row_is(rr(FN_DIV, 3, 4), 3, -1, 1);
		row_is(ii(FN_DIV, -7, 2), 0, -3, 0);
		row_is(ii(FN_DIV, 7, -2), 0, -3, 0);
		row_is(ri(FN_ADD, 31, -1), 31, -1, 0);
		row_is(rr(FN_MOV, 30, 31), 30, -1, 0);
		row_is(ri(FN_ADD, 31, 0), 31, 0, 0);
		row_is(rr(FN_MOV, 30, 30), 30, 0, 0);
		row(ir(FN_MOV, $urandom, 1));
		row(ri(FN_MOV, 7, $urandom));
		row_is(ii(FN_CMP, VAL_MAX, VAL_MIN), 0, 1, 0);
		row_is(ii(FN_CMP, VAL_MIN, VAL_MAX), 0, -1, 0);
		row_is(rr(FN_CMP, 1, 1), 0, 0, 0);
		row_is(cmd_t'{FN_UNDEF_A, 1'b1, 5'h1f, '1, 1'b1, 5'h1f, '1}, 0, 0, 0);
		row_is(ii(FN_UNDEF_B, VAL_MIN, VAL_MAX), 0, 0, 0);
		row(rr(FN_MUL, 2, 2));
		row(ir(FN_SUB, 0, 7));
		row(rr(FN_ADD, 0, 31));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send(plan[i].c, plan[i].known, plan[i].r);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				bursts_on = 1'b0;
			pick = $urandom_range(0, 15);
			if (pick < 14)
				c.func = FUNC_W'(pick % 6);
			else if (pick == 14)
				c.func = FN_UNDEF_A;
			else
				c.func = FN_UNDEF_B;
			c.first_is_reg = ($urandom_range(0, 3) != 0);
			c.first_index = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
				: $urandom_range(0, 31));
			c.first_imm = pick_value();
			c.second_is_reg = ($urandom_range(0, 2) != 0);
			c.second_index = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
				: $urandom_range(0, 31));
			c.second_imm = pick_value();
			send(c, 1'b0, '0);
		end
		cmd_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("PASS register_calculator_execute_unit");
		else
			$display("FAIL register_calculator_execute_unit");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/rcx_pkg.sv
rtl/core/rcx_regfile.sv
rtl/core/rcx_divider.sv
rtl/core/register_calculator_execute_unit.sv
dv/tb_register_calculator_execute_unit.sv
